### sv/b2d_pkg.sv
`default_nettype none
package b2d_pkg;

	// number classes found by the front end
	typedef enum logic [1:0] {
		CLS_NUM  = 2'd0,
		CLS_ZERO = 2'd1,
		CLS_INF  = 2'd2,
		CLS_NAN  = 2'd3
	} num_class_t;

	// classified item handed from front to back
	typedef struct packed {
		logic             sign;
		num_class_t       cls;
		logic [52:0]      mant;
		logic signed [11:0] expo;
	} b2d_item_t;

	localparam logic [19:0] SCALE      = 20'd1000000;
	localparam int          P_BITS     = 73;
	localparam int          LIMB_BITS  = 16;
	localparam logic [10:0] EXP_ONES   = 11'h7FF;
	localparam int          EXP_BIAS   = 1075;
	localparam logic [7:0]  CH_MINUS   = 8'd45;
	localparam logic [7:0]  CH_POINT   = 8'd46;
	localparam logic [7:0]  CH_ZERO    = 8'd48;

	// letters of "inf" and "nan"
	function automatic logic [7:0] special_char(input logic is_nan, input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0:    c = is_nan ? 8'h6E : 8'h69;
			2'd1:    c = is_nan ? 8'h61 : 8'h6E;
			default: c = is_nan ? 8'h6E : 8'h66;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

### sv/b2d_front.sv
`default_nettype none
module b2d_front import b2d_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] upper_word,
	input  wire logic [31:0] lower_word,
	output logic             push_valid,
	input  wire logic        push_ready,
	output b2d_item_t        push_item
);

	logic       valid_s1;
	b2d_item_t  item_s1;
	b2d_item_t  cls_item;
	logic [10:0] biased;
	logic [10:0] biased_eff;
	logic        frac_zero;

	// split the fields and classify
	always_comb begin
		biased     = upper_word[30:20];
		frac_zero  = (upper_word[19:0] == 20'd0) && (lower_word == 32'd0);
		biased_eff = (biased == 11'd0) ? 11'd1 : biased;
		cls_item.sign = upper_word[31];
		cls_item.mant = {(biased != 11'd0), upper_word[19:0], lower_word};
		cls_item.expo = $signed({1'b0, biased_eff}) - 12'(EXP_BIAS);
		if (biased == EXP_ONES) begin
			cls_item.cls = frac_zero ? CLS_INF : CLS_NAN;
		end else if (biased == 11'd0 && frac_zero) begin
			cls_item.cls = CLS_ZERO;
		end else begin
			cls_item.cls = CLS_NUM;
		end
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	// one register stage in front of the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= cls_item;
		end
	end

endmodule
`default_nettype wire

### sv/b2d_queue.sv
`default_nettype none
module b2d_queue import b2d_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push_valid,
	output logic            push_ready,
	input  wire b2d_item_t  push_item,
	output logic            pop_valid,
	input  wire logic       pop_ready,
	output b2d_item_t       pop_item
);

	b2d_item_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// two-entry fifo pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop) count_q <= count_q + 2'd1;
			else if (!do_push && do_pop) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

### sv/b2d_back.sv
`default_nettype none
module b2d_back import b2d_pkg::*; #(
	parameter int CHARS_PER_RESULT = 8,
	parameter int WORK_BITS        = 1088
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_ready,
	input  wire b2d_item_t  item,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0][7:0] out_chars,
	output logic [3:0]      out_count,
	output logic            out_final
);

	localparam int NLIMB     = (WORK_BITS + LIMB_BITS - 1) / LIMB_BITS;
	localparam int LW        = $clog2(NLIMB);
	localparam int MAX_DIG   = (WORK_BITS * 30103) / 100000 + 2;
	localparam int DW        = $clog2(MAX_DIG);
	localparam int NDW       = $clog2(MAX_DIG + 1);
	localparam int TW        = $clog2(MAX_DIG + 3);
	localparam int CW        = (CHARS_PER_RESULT > 1) ? $clog2(CHARS_PER_RESULT) : 1;
	localparam int WIDE_BITS = P_BITS + LIMB_BITS;

	typedef enum logic [10:0] {
		ST_IDLE      = 11'b000_0000_0001,
		ST_MUL       = 11'b000_0000_0010,
		ST_SUM       = 11'b000_0000_0100,
		ST_SCALE     = 11'b000_0000_1000,
		ST_FILL      = 11'b000_0001_0000,
		ST_DIV_START = 11'b000_0010_0000,
		ST_DIV_RUN   = 11'b000_0100_0000,
		ST_TXT_INIT  = 11'b000_1000_0000,
		ST_TXT_ADDR  = 11'b001_0000_0000,
		ST_TXT_CHAR  = 11'b010_0000_0000,
		ST_OUT       = 11'b100_0000_0000
	} back_state_t;

	back_state_t state_q;

	logic              sign_q;
	num_class_t        cls_q;
	logic [52:0]       mant_q;
	logic signed [11:0] expo_q;
	logic [51:0]       p_lo_q;
	logic [40:0]       p_hi_q;
	logic [P_BITS-1:0] prod_q;
	logic [P_BITS-1:0] val_q;
	logic [9:0]        lsh_q;
	logic [LW-1:0]     k_q;
	logic [LW-1:0]     top_q;
	logic              any_q;
	logic [LW-1:0]     p_q;
	logic [3:0]        rem_q;
	logic              found_q;
	logic [LW-1:0]     newtop_q;
	logic [NDW-1:0]    nd_q;
	logic [TW-1:0]     t_q;
	logic [TW-1:0]     len_q;
	logic [CW-1:0]     j_q;
	logic              use_mem_q;
	logic [7:0]        lit_q;
	logic [7:0]        chunk_q [CHARS_PER_RESULT];
	logic [3:0]        count_q;
	logic              final_q;

	// limb store and digit store
	logic [LIMB_BITS-1:0] limb_mem [NLIMB];
	logic                 limb_we;
	logic [LW-1:0]        limb_wa;
	logic [LIMB_BITS-1:0] limb_wd;
	logic [LW-1:0]        limb_ra;
	logic [LIMB_BITS-1:0] limb_rd_q;
	logic [3:0]           dig_mem [MAX_DIG];
	logic [DW-1:0]        dig_ra;
	logic [3:0]           dig_rd_q;

	logic [P_BITS-1:0]    scale_val;
	logic [10:0]          sh;
	logic [P_BITS-1:0]    shifted;
	logic [P_BITS-1:0]    rb_word;
	logic [WIDE_BITS-1:0] wide;
	int                   s;
	logic [LIMB_BITS-1:0] fill_word;
	logic [19:0]          dx;
	logic [39:0]          dprod;
	logic [15:0]          dq;
	logic [19:0]          dr_full;
	logic [3:0]           dr;
	logic [TW-1:0]        dd;
	logic [TW-1:0]        u;
	logic [TW-1:0]        idx;
	logic                 txt_mem;
	logic [7:0]           txt_lit;
	logic [7:0]           cur_char;
	logic                 last_char;

	always_ff @(posedge clk) begin
		if (limb_we) limb_mem[limb_wa] <= limb_wd;
		limb_rd_q <= limb_mem[limb_ra];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV_RUN && p_q == '0) dig_mem[nd_q[DW-1:0]] <= dr;
		dig_rd_q <= dig_mem[dig_ra];
	end

	// rounding shift for negative exponents
	always_comb begin
		sh      = 11'(-expo_q);
		shifted = prod_q >> sh;
		rb_word = prod_q >> (sh - 11'd1);
		if (expo_q >= 0) begin
			scale_val = prod_q;
		end else if (sh <= 11'(P_BITS)) begin
			scale_val = shifted + P_BITS'(rb_word[0]);
		end else begin
			scale_val = '0;
		end
	end

	// one limb of val << lsh
	always_comb begin
		wide = {val_q, {LIMB_BITS{1'b0}}};
		s    = LIMB_BITS * int'(k_q) + LIMB_BITS - int'(lsh_q);
		if (s >= 0 && s < WIDE_BITS) fill_word = LIMB_BITS'(wide >> s);
		else fill_word = '0;
	end

	// one limb of the divide by ten, reciprocal multiply
	always_comb begin
		dx      = {rem_q, limb_rd_q};
		dprod   = 40'(dx) * 40'(20'hCCCCD);
		dq      = dprod[38:23];
		dr_full = dx - {1'b0, dq, 3'b000} - {3'b000, dq, 1'b0};
		dr      = dr_full[3:0];
	end

	// character at text position t
	always_comb begin
		dd      = (nd_q < NDW'(7)) ? TW'(7) : TW'(nd_q);
		u       = t_q - TW'(sign_q);
		idx     = '0;
		txt_mem = 1'b0;
		txt_lit = CH_ZERO;
		if (sign_q && t_q == '0) begin
			txt_lit = CH_MINUS;
		end else if (cls_q == CLS_INF || cls_q == CLS_NAN) begin
			txt_lit = special_char(cls_q == CLS_NAN, u[1:0]);
		end else if (u == dd - TW'(6)) begin
			txt_lit = CH_POINT;
		end else begin
			idx = (u < dd - TW'(6)) ? (dd - TW'(1) - u) : (dd - u);
			txt_mem = (idx < TW'(nd_q));
		end
		cur_char  = use_mem_q ? (CH_ZERO + {4'b0000, dig_rd_q}) : lit_q;
		last_char = (t_q == len_q - TW'(1));
	end

	// store controls
	always_comb begin
		limb_we = 1'b0;
		limb_wa = k_q;
		limb_wd = fill_word;
		limb_ra = top_q;
		dig_ra  = idx[DW-1:0];
		if (state_q == ST_FILL) begin
			limb_we = 1'b1;
		end else if (state_q == ST_DIV_RUN) begin
			limb_we = 1'b1;
			limb_wa = p_q;
			limb_wd = dq;
			limb_ra = p_q - LW'(1);
		end
	end

	assign item_ready = (state_q == ST_IDLE);
	assign out_valid  = (state_q == ST_OUT);
	assign out_count  = count_q;
	assign out_final  = final_q;

	genvar gi;
	generate
		for (gi = 0; gi < 8; gi++) begin : g_char
			if (gi < CHARS_PER_RESULT) begin : g_used
				assign out_chars[gi] = chunk_q[gi];
			end else begin : g_unused
				assign out_chars[gi] = 8'd0;
			end
		end
	endgenerate

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nd_q    <= '0;
			t_q     <= '0;
			len_q   <= '0;
			j_q     <= '0;
			count_q <= 4'd0;
			final_q <= 1'b0;
			for (int i = 0; i < CHARS_PER_RESULT; i++) chunk_q[i] <= 8'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						sign_q <= item.sign;
						cls_q  <= item.cls;
						mant_q <= item.mant;
						expo_q <= item.expo;
						nd_q   <= '0;
						state_q <= (item.cls == CLS_NUM) ? ST_MUL : ST_TXT_INIT;
					end
				end
				ST_MUL: begin
					p_lo_q  <= 52'(mant_q[31:0]) * 52'(SCALE);
					p_hi_q  <= 41'(mant_q[52:32]) * 41'(SCALE);
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					prod_q  <= {p_hi_q, 32'd0} + P_BITS'(p_lo_q);
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					val_q   <= scale_val;
					lsh_q   <= (expo_q >= 0) ? expo_q[9:0] : 10'd0;
					k_q     <= '0;
					top_q   <= '0;
					any_q   <= 1'b0;
					state_q <= ST_FILL;
				end
				ST_FILL: begin
					if (fill_word != '0) begin
						top_q <= k_q;
						any_q <= 1'b1;
					end
					k_q <= k_q + LW'(1);
					if (k_q == LW'(NLIMB - 1)) begin
						state_q <= (any_q || fill_word != '0) ? ST_DIV_START : ST_TXT_INIT;
					end
				end
				ST_DIV_START: begin
					p_q      <= top_q;
					rem_q    <= 4'd0;
					found_q  <= 1'b0;
					newtop_q <= '0;
					state_q  <= ST_DIV_RUN;
				end
				ST_DIV_RUN: begin
					rem_q <= dr;
					if (dq != 16'd0 && !found_q) begin
						found_q  <= 1'b1;
						newtop_q <= p_q;
					end
					if (p_q != '0) begin
						p_q <= p_q - LW'(1);
					end else begin
						nd_q <= nd_q + NDW'(1);
						if (found_q || dq != 16'd0) begin
							top_q   <= found_q ? newtop_q : '0;
							state_q <= ST_DIV_START;
						end else begin
							state_q <= ST_TXT_INIT;
						end
					end
				end
				ST_TXT_INIT: begin
					t_q <= '0;
					j_q <= '0;
					if (cls_q == CLS_INF || cls_q == CLS_NAN) begin
						len_q <= TW'(sign_q) + TW'(3);
					end else begin
						len_q <= TW'(sign_q) + dd + TW'(1);
					end
					state_q <= ST_TXT_ADDR;
				end
				ST_TXT_ADDR: begin
					use_mem_q <= txt_mem;
					lit_q     <= txt_lit;
					state_q   <= ST_TXT_CHAR;
				end
				ST_TXT_CHAR: begin
					chunk_q[j_q] <= cur_char;
					if (last_char || j_q == CW'(CHARS_PER_RESULT - 1)) begin
						count_q <= 4'(j_q) + 4'd1;
						final_q <= last_char;
						state_q <= ST_OUT;
					end else begin
						j_q     <= j_q + CW'(1);
						t_q     <= t_q + TW'(1);
						state_q <= ST_TXT_ADDR;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						for (int i = 0; i < CHARS_PER_RESULT; i++) chunk_q[i] <= 8'd0;
						j_q <= '0;
						t_q <= t_q + TW'(1);
						state_q <= final_q ? ST_IDLE : ST_TXT_ADDR;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### sv/binary64_to_fixed_decimal_text.sv
// steps: inf, nan and zero go straight to the text states after the back end picks them up
// numbers: multiply, sum, scale, fill NLIMB (68) limbs, then per decimal digit one divider pass
//   over the active 16-bit limbs, one limb per cycle, then the text states emit the characters
// flow: one item in the back end at a time; a two-entry queue takes new items meanwhile
// reset: arst_n clears all control state, queue empty, back end idle, no result pending
`default_nettype none
module binary64_to_fixed_decimal_text import b2d_pkg::*; #(
	parameter int CHARS_PER_RESULT = 8,
	parameter int WORK_BITS        = 1088
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] upper_word,
	input  wire logic [31:0] lower_word,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       char_0,
	output logic [7:0]       char_1,
	output logic [7:0]       char_2,
	output logic [7:0]       char_3,
	output logic [7:0]       char_4,
	output logic [7:0]       char_5,
	output logic [7:0]       char_6,
	output logic [7:0]       char_7,
	output logic [3:0]       valid_count,
	output logic             final_chunk
);

	logic            push_valid;
	logic            push_ready;
	b2d_item_t       push_item;
	logic            pop_valid;
	logic            pop_ready;
	b2d_item_t       pop_item;
	logic [7:0][7:0] chars;

	b2d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.upper_word (upper_word),
		.lower_word (lower_word),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	b2d_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	b2d_back #(
		.CHARS_PER_RESULT (CHARS_PER_RESULT),
		.WORK_BITS        (WORK_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (pop_valid),
		.item_ready (pop_ready),
		.item       (pop_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_chars  (chars),
		.out_count  (valid_count),
		.out_final  (final_chunk)
	);

	assign char_0 = chars[0];
	assign char_1 = chars[1];
	assign char_2 = chars[2];
	assign char_3 = chars[3];
	assign char_4 = chars[4];
	assign char_5 = chars[5];
	assign char_6 = chars[6];
	assign char_7 = chars[7];

	// a shown chunk carries at least one and at most a full chunk of characters
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (valid_count != 4'd0 && valid_count <= 4'(CHARS_PER_RESULT)))
		else $error("chunk count out of range");

	// only the last chunk of a number may be short
	a_short_final: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !final_chunk) |-> (valid_count == 4'(CHARS_PER_RESULT)))
		else $error("short chunk before the end of the text");

	// after the last chunk leaves, no chunk shows in the next cycle
	a_gap_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && final_chunk) |=> !out_valid)
		else $error("chunk shown right after the final one");

endmodule
`default_nettype wire

### sim/binary64_to_fixed_decimal_text_tb.sv
`default_nettype none
module binary64_to_fixed_decimal_text_tb import b2d_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIDE = 1100;
	localparam int STALL_LIMIT = 100000;

	typedef struct packed {
		logic [7:0][7:0] chars;
		logic [3:0]      count;
		logic            last;
	} chunk_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [31:0] upper_word, lower_word;
	logic [7:0] char_0, char_1, char_2, char_3, char_4, char_5, char_6, char_7;
	logic [3:0] valid_count;
	logic final_chunk;

	chunk_t expected_chunks[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit hold_request = 0;
	bit no_gaps = 0;

	binary64_to_fixed_decimal_text u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.upper_word(upper_word), .lower_word(lower_word),
		.out_valid(out_valid), .out_ready(out_ready),
		.char_0(char_0), .char_1(char_1), .char_2(char_2), .char_3(char_3),
		.char_4(char_4), .char_5(char_5), .char_6(char_6), .char_7(char_7),
		.valid_count(valid_count), .final_chunk(final_chunk)
	);

	// clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// gap length: mostly short, now and then long
	function automatic int pick_gap();
		if (no_gaps) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 200);
		if ($urandom_range(0, 1) == 0) return 0;
		return $urandom_range(1, 3);
	endfunction

	// format one binary64 pattern as %f text and split it into chunks
	task automatic predict_text(input logic [31:0] hi, input logic [31:0] lo);
		logic [WIDE-1:0] scaled;
		logic [10:0] biased;
		logic [52:0] mant;
		logic round_up;
		byte unsigned txt[$];
		byte unsigned digits[$];
		int e, nd;
		chunk_t c;
		string s;
		biased = hi[30:20];
		if (hi[31]) txt.push_back(CH_MINUS);
		if (biased == EXP_ONES) begin
			s = ({hi[19:0], lo} == 52'd0) ? "inf" : "nan";
			for (int i = 0; i < 3; i++) txt.push_back(s[i]);
		end else if (biased == 0 && {hi[19:0], lo} == 52'd0) begin
			s = "0.000000";
			for (int i = 0; i < 8; i++) txt.push_back(s[i]);
		end else begin
			mant = {biased != 0, hi[19:0], lo};
			e = (biased != 0 ? int'(biased) : 1) - EXP_BIAS;
			scaled = mant;
			if (e >= 0) begin
				scaled = (scaled << e) * 1000000;
			end else begin
				scaled = scaled * 1000000;
				round_up = scaled[-e - 1];
				scaled = (scaled >> (-e)) + round_up;
			end
			// decimal digits, least significant first
			while (scaled != 0) begin
				digits.push_back(CH_ZERO + byte'(scaled % 10));
				scaled = scaled / 10;
			end
			while (digits.size() < 7) digits.push_back(CH_ZERO);
			for (nd = digits.size() - 1; nd >= 0; nd--) begin
				if (nd == 5) txt.push_back(CH_POINT);
				txt.push_back(digits[nd]);
			end
		end
		for (int p = 0; p < txt.size(); p += 8) begin
			c = '0;
			for (int j = 0; j < 8 && p + j < txt.size(); j++) begin
				c.chars[j] = txt[p + j];
				c.count = c.count + 1;
			end
			c.last = (p + 8 >= txt.size());
			expected_chunks.push_back(c);
		end
	endtask

	// offer one number and wait for it to be taken
	task automatic send_number(input logic [31:0] hi, input logic [31:0] lo);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		upper_word <= hi;
		lower_word <= lo;
		do @(posedge clk); while (!in_ready);
		predict_text(hi, lo);
	endtask

	// let everything drain with the input idle
	task automatic wait_drained();
		in_valid <= 0;
		while (expected_chunks.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// receiver side with random stalls and one long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 0;
			end else if (hold_request) begin
				hold_request = 0;
				stall_left = 3000;
				out_ready <= 0;
			end else if (out_ready && out_valid && !no_gaps && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
				out_ready <= (stall_left == 0);
			end else begin
				out_ready <= 1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		chunk_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got.chars = {char_7, char_6, char_5, char_4, char_3, char_2, char_1, char_0};
			got.count = valid_count;
			got.last = final_chunk;
			if (expected_chunks.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected chunk %h count %0d last %b",
						got.chars, got.count, got.last);
			end else begin
				want = expected_chunks.pop_front();
				if (got != want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("chunk mismatch: exp %h/%0d/%b got %h/%0d/%b",
							want.chars, want.count, want.last,
							got.chars, got.count, got.last);
				end
			end
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// extremes and each special class
	task automatic test_directed();
		send_number(32'h0000_0000, 32'h0000_0000);
		send_number(32'h8000_0000, 32'h0000_0000);
		send_number(32'h7FF0_0000, 32'h0000_0000);
		send_number(32'hFFF0_0000, 32'h0000_0000);
		send_number(32'h7FF8_0000, 32'h0000_0000);
		send_number(32'hFFF0_0000, 32'h0000_0001);
		send_number(32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_number(32'h3FF0_0000, 32'h0000_0000);
		send_number(32'hBFF8_0000, 32'h0000_0000);
		send_number(32'h3F80_0000, 32'h0000_0000);
		send_number(32'h3FB9_9999, 32'h9999_999A);
		send_number(32'h3EB0_C6F7, 32'hA0B5_ED8D);
		send_number(32'h3EA0_C6F7, 32'hA0B5_ED8D);
		send_number(32'h0000_0000, 32'h0000_0001);
		send_number(32'h800F_FFFF, 32'hFFFF_FFFF);
		send_number(32'h0010_0000, 32'h0000_0000);
		send_number(32'h7FEF_FFFF, 32'hFFFF_FFFF);
		send_number(32'hFFEF_FFFF, 32'hFFFF_FFFF);
		send_number(32'h4341_C379, 32'h37E0_8000);
		send_number(32'h412E_847F, 32'hFFFF_FFFF);
		wait_drained();
	endtask

	// random numbers, mostly in the moderate range
	task automatic test_random();
		logic [31:0] hi, lo;
		int kind;
		for (int i = 0; i < 130; i++) begin
			no_gaps = (i >= 60 && i < 75);
			hi = $urandom;
			lo = $urandom;
			kind = $urandom_range(0, 9);
			if (kind < 7) hi[30:20] = 11'($urandom_range(1023 - 30, 1023 + 40));
			else if (kind == 7) hi[30:20] = 11'($urandom_range(0, 2));
			else if (kind == 8) hi[30:20] = $urandom_range(0, 1) ? EXP_ONES : 11'd0;
			send_number(hi, lo);
		end
		no_gaps = 0;
		wait_drained();
	endtask

	// long receiver hold-off while numbers keep coming
	task automatic test_backpressure();
		hold_request = 1;
		no_gaps = 1;
		for (int i = 0; i < 10; i++)
			send_number({1'($urandom), 11'($urandom_range(1000, 1050)), 20'($urandom)},
				$urandom);
		no_gaps = 0;
		wait_drained();
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		upper_word = 0;
		lower_word = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		if (mismatches == 0 && expected_chunks.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
`default_nettype wire

### filelist.f
sv/b2d_pkg.sv
sv/b2d_front.sv
sv/b2d_queue.sv
sv/b2d_back.sv
sv/binary64_to_fixed_decimal_text.sv
sim/binary64_to_fixed_decimal_text_tb.sv
